/* hdl/tksfp_pkg.sv */
// Shared constants and types for the two-kind serial frame parser.
package tksfp_pkg;

  // Frame delimiter and type bytes
  localparam logic [7:0] HdrByte  = 8'hAA;
  localparam logic [7:0] TypeTask = 8'h28;
  localparam logic [7:0] TypeDist = 8'h20;
  localparam logic [7:0] TrlByte  = 8'hFF;

  // Frame kind codes
  localparam logic KindTask = 1'b0;
  localparam logic KindDist = 1'b1;

  // Parser position codes
  localparam logic [2:0] PosHunt  = 3'd0;
  localparam logic [2:0] PosType  = 3'd1;
  localparam logic [2:0] PosPay0  = 3'd2;
  localparam logic [2:0] PosPay1  = 3'd3;
  localparam logic [2:0] PosPay2  = 3'd4;
  localparam logic [2:0] PosTrail = 3'd5;

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // One decoded frame
  typedef struct packed {
    logic        frame_kind;
    logic [7:0]  task_number;
    logic [7:0]  range_flag;
    logic [15:0] range_value;
  } result_t;

endpackage

/* hdl/two_kind_serial_frame_parser_core.sv */
// Top level of the two-kind serial frame parser.
//
//  channel  | dir | tdata                          | tuser
//  s_axis   | in  | rx_byte[7:0]                   | -
//  m_axis   | out | task_number[7:0],              | frame_kind
//           |     | range_flag[15:8],              |
//           |     | range_value[31:16]             |
//
// One byte per cycle while s_axis_tready_o is high: each byte is decoded in the cycle it is
// transferred, and a finished frame is registered in the output buffer and shown on m_axis.
// Reset puts the parser back to hunting for a header and empties the buffer.
// A two-entry output buffer lets bytes keep flowing while a result waits;
// s_axis_tready_o drops only when both entries are full.
module two_kind_serial_frame_parser_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [tksfp_pkg::InDataW-1:0]      s_axis_tdata_i,   // rx_byte[7:0]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // task_number[7:0], range_flag[15:8], range_value[31:16]
  output logic [tksfp_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tuser_o    // frame_kind
);
  import tksfp_pkg::*;

  logic    byte_valid;
  logic    res_valid;
  logic    space;
  result_t res, out_res;

  assign byte_valid = s_axis_tvalid_i & space;
  assign s_axis_tready_o = space;

  // Frame decode
  tksfp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (s_axis_tdata_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result buffering
  tksfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {out_res.range_value, out_res.range_flag, out_res.task_number};
  assign m_axis_tuser_o = out_res.frame_kind;

endmodule

/* hdl/tksfp_parse.sv */
// Byte-wise frame parser: position register, payload store and result decode.
module tksfp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output tksfp_pkg::result_t  res_o
);
  import tksfp_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic       kind_q, kind_d;
  logic [7:0] pay_q [3];

  // Next position and result decode for the current byte
  always_comb begin
    pos_d       = PosHunt;
    kind_d      = KindTask;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (pos_q)
      PosHunt: begin
        pos_d = (byte_i == HdrByte) ? PosType : PosHunt;
      end
      PosType: begin
        if (byte_i == TypeDist) begin
          kind_d = KindDist;
          pos_d  = PosPay0;
        end else if (byte_i == TypeTask) begin
          kind_d = KindTask;
          pos_d  = PosPay0;
        end else if (byte_i == HdrByte) begin
          kind_d = kind_q;
          pos_d  = PosType;
        end
      end
      PosPay0: begin
        kind_d = kind_q;
        pos_d  = PosPay1;
      end
      PosPay1: begin
        if (kind_q == KindDist) begin
          kind_d = kind_q;
          pos_d  = PosPay2;
        end else if (byte_i == TrlByte) begin
          res_valid_o       = 1'b1;
          res_o.frame_kind  = KindTask;
          res_o.task_number = pay_q[0];
        end
      end
      PosPay2: begin
        if (kind_q == KindDist) begin
          kind_d = kind_q;
          pos_d  = PosTrail;
        end
      end
      PosTrail: begin
        if (kind_q == KindDist && byte_i == TrlByte) begin
          res_valid_o       = 1'b1;
          res_o.frame_kind  = KindDist;
          res_o.range_flag  = pay_q[0];
          res_o.range_value = {pay_q[1], pay_q[2]};
        end
      end
      default: begin
        pos_d = PosHunt;
      end
    endcase
    if (!byte_valid_i) begin
      res_valid_o = 1'b0;
    end
  end

  // Position and kind registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosHunt;
      kind_q <= KindTask;
    end else if (byte_valid_i) begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
    end
  end

  // Payload store, written in frame order
  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      if (pos_q == PosPay0) begin
        pay_q[0] <= byte_i;
      end
      if (pos_q == PosPay1 && kind_q == KindDist) begin
        pay_q[1] <= byte_i;
      end
      if (pos_q == PosPay2 && kind_q == KindDist) begin
        pay_q[2] <= byte_i;
      end
    end
  end

endmodule

/* hdl/tksfp_out_buf.sv */
// Two-entry result buffer: output register plus skid stage.
module tksfp_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tksfp_pkg::result_t  push_data_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output tksfp_pkg::result_t  data_o
);
  import tksfp_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_valid_q & ready_i;
  assign space_o = ~skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      main_valid_q <= 1'b1;
      skid_valid_q <= main_valid_q & ~pop;
    end else if (pop) begin
      main_valid_q <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  // Payload; a push only happens while the skid stage is empty
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end else if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end
  end

endmodule

/* bench/two_kind_serial_frame_parser_core_tb.sv */
// Testbench for the two-kind serial frame parser: byte stimulus, frame prediction, result check.
`timescale 1ns / 100ps

module two_kind_serial_frame_parser_core_tb;
  import tksfp_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;   // rx_byte[7:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b1;
  // task_number[7:0], range_flag[15:8], range_value[31:16]
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;         // frame_kind

  // Parser state mirrored by the predictor
  logic [2:0] pred_pos;
  logic       pred_kind;
  logic [7:0] pred_payload [3];

  result_t     frames_expected [$];
  result_t     predicted;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  two_kind_serial_frame_parser_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Predict the frame finished by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    bit done;
    done = 1'b0;
    r    = '0;
    case (pred_pos)
      PosHunt: begin
        if (b == HdrByte) pred_pos = PosType;
      end
      PosType: begin
        if (b == TypeDist) begin
          pred_kind = KindDist;
          pred_pos  = PosPay0;
        end else if (b == TypeTask) begin
          pred_kind = KindTask;
          pred_pos  = PosPay0;
        end else if (b != HdrByte) begin
          pred_pos  = PosHunt;
          pred_kind = KindTask;
        end
      end
      PosPay0: begin
        pred_payload[0] = b;
        pred_pos        = PosPay1;
      end
      PosPay1: begin
        if (pred_kind == KindDist) begin
          pred_payload[1] = b;
          pred_pos        = PosPay2;
        end else begin
          if (b == TrlByte) begin
            r.frame_kind  = KindTask;
            r.task_number = pred_payload[0];
            done          = 1'b1;
          end
          pred_pos  = PosHunt;
          pred_kind = KindTask;
        end
      end
      PosPay2: begin
        if (pred_kind == KindDist) begin
          pred_payload[2] = b;
          pred_pos        = PosTrail;
        end else begin
          pred_pos  = PosHunt;
          pred_kind = KindTask;
        end
      end
      PosTrail: begin
        if (pred_kind == KindDist && b == TrlByte) begin
          r.frame_kind  = KindDist;
          r.range_flag  = pred_payload[0];
          r.range_value = {pred_payload[1], pred_payload[2]};
          done          = 1'b1;
        end
        pred_pos  = PosHunt;
        pred_kind = KindTask;
      end
      default: begin
        pred_pos  = PosHunt;
        pred_kind = KindTask;
      end
    endcase
    return done;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Compare one output transfer with the oldest expected frame
  task automatic check_frame(input result_t got);
    result_t want;
    if (frames_expected.size() == 0) begin
      report_mismatch("unexpected frame, kind/task",
                      16'({got.frame_kind, got.task_number}), '0);
      return;
    end
    want = frames_expected.pop_front();
    if (got.frame_kind !== want.frame_kind)
      report_mismatch("frame_kind", 16'(got.frame_kind), 16'(want.frame_kind));
    if (got.task_number !== want.task_number)
      report_mismatch("task_number", 16'(got.task_number), 16'(want.task_number));
    if (got.range_flag !== want.range_flag)
      report_mismatch("range_flag", 16'(got.range_flag), 16'(want.range_flag));
    if (got.range_value !== want.range_value)
      report_mismatch("range_value", got.range_value, want.range_value);
  endtask

  // Monitor: results first, then predict from the byte taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        check_frame('{frame_kind:  m_axis_tuser_o,
                      task_number: m_axis_tdata_o[7:0],
                      range_flag:  m_axis_tdata_o[15:8],
                      range_value: m_axis_tdata_o[31:16]});
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (parse_byte(s_axis_tdata_i, predicted)) frames_expected.push_back(predicted);
      end
    end
  end

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_task_frame(input logic [7:0] num, input logic [7:0] trl);
    send_byte(HdrByte);
    send_byte(TypeTask);
    send_byte(num);
    send_byte(trl);
  endtask

  task automatic send_dist_frame(input logic [7:0] flag, input logic [15:0] distance,
                                 input logic [7:0] trl);
    send_byte(HdrByte);
    send_byte(TypeDist);
    send_byte(flag);
    send_byte(distance[15:8]);
    send_byte(distance[7:0]);
    send_byte(trl);
  endtask

  // Task frames at the extremes of the task number and with the header byte as task number
  task automatic test_task_frames();
    send_task_frame(8'h00, TrlByte);
    send_task_frame(8'hFF, TrlByte);
    send_task_frame(HdrByte, TrlByte);
  endtask

  // Distance frames, including byte order of the distance
  task automatic test_distance_frames();
    send_dist_frame(8'h00, 16'h0000, TrlByte);
    send_dist_frame(8'hFF, 16'hFFFF, TrlByte);
    send_dist_frame(8'h5A, 16'h1234, TrlByte);
  endtask

  task automatic test_special_cases();
    // noise while hunting is ignored
    send_byte(8'h00);
    send_byte(TrlByte);
    send_byte(TypeTask);
    send_byte(TypeDist);
    // unknown type drops back to hunting
    send_byte(HdrByte);
    send_byte(8'h55);
    send_task_frame(8'h07, TrlByte);
    // repeated header stays in the type position
    send_byte(HdrByte);
    send_task_frame(8'h3C, TrlByte);
    // bad trailer of a task frame; the header in its place is not taken again
    send_task_frame(8'h11, HdrByte);
    send_byte(TypeTask);
    send_byte(8'h22);
    send_byte(TrlByte);
    // bad trailer of a distance frame, then a clean frame
    send_dist_frame(8'h01, 16'h0203, 8'hFE);
    send_task_frame(8'h09, TrlByte);
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  bad_trl;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at        = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick    = $urandom_range(0, 99);
      bad_trl = 8'($urandom_range(0, 254));
      if (pick < 40) begin
        send_task_frame(8'($urandom_range(0, 255)), TrlByte);
      end else if (pick < 80) begin
        send_dist_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), TrlByte);
      end else if (pick < 85) begin
        send_task_frame(8'($urandom_range(0, 255)), bad_trl);
      end else if (pick < 90) begin
        send_dist_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), bad_trl);
      end else if (pick < 94) begin
        send_byte(HdrByte);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    pred_pos        = PosHunt;
    pred_kind       = KindTask;
    pred_payload[0] = '0;
    pred_payload[1] = '0;
    pred_payload[2] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_task_frames();
    test_distance_frames();
    test_special_cases();
    test_random_traffic(0, 0, 250);
    test_random_traffic(62, 0, 250);
    test_random_traffic(0, 62, 250);
    test_random_traffic(8, 8, 250);

    s_axis_tvalid_i <= 1'b0;
    while (frames_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
